### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the sequencer RTL
// Clocked property checks that are disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// A condition that must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
   `ASSERT_CLK(lbl, !(cond), msg)

`endif

### rtl/nfts_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// NAND transfer sequencer package
// Geometry constants, bus cycle slot numbering and the job record that
// travels from the front end through the queue to the back end.
// ---------------------------------------------------------------------------
package nfts_pkg;

   // Page and block sizes are powers of two.
   localparam int PAGE_BYTES      = 2048;
   localparam int PAGE_BITS       = $clog2(PAGE_BYTES);
   localparam int BLOCK_BYTES     = 131072;
   localparam int BLOCK_BITS      = $clog2(BLOCK_BYTES);
   localparam int PAGES_PER_BLOCK = BLOCK_BYTES / PAGE_BYTES;

   localparam int ROW_W  = 24;
   localparam int ADDR_W = 32;
   localparam int LEN_W  = 32;
   localparam int BLK_W  = LEN_W - BLOCK_BITS;
   localparam int DATA_W = 8;

   // Depth of the job queue; a power of two.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Every bus cycle a job can produce has a slot. A job is a set of slots,
   // and they leave in ascending slot order.
   localparam int SLOT_SEL    = 0;
   localparam int SLOT_ERR    = 1;
   localparam int SLOT_RDATA  = 2;
   localparam int SLOT_WDATA  = 3;
   localparam int SLOT_CMD10  = 4;
   localparam int SLOT_WAIT   = 5;
   localparam int SLOT_CMD00  = 6;
   localparam int SLOT_CMD80  = 7;
   localparam int SLOT_CMD60  = 8;
   localparam int SLOT_COL0   = 9;
   localparam int SLOT_COL1   = 10;
   localparam int SLOT_ROW0   = 11;
   localparam int SLOT_ROW1   = 12;
   localparam int SLOT_ROW2   = 13;
   localparam int SLOT_CMD30  = 14;
   localparam int SLOT_CMDD0  = 15;
   localparam int SLOT_CMD10B = 16;
   localparam int SLOT_WAIT2  = 17;
   localparam int SLOT_DESEL  = 18;
   localparam int SLOT_CNT    = 19;

   typedef logic [SLOT_CNT-1:0] slot_mask_type;

   typedef struct packed {
      slot_mask_type           mask;
      logic [ROW_W-1:0]        page;
      logic [PAGE_BITS-1:0]    column;
      logic [DATA_W-1:0]       data;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

### rtl/nfts_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// NAND transfer sequencer front end
// Accepts request beats, keeps the transfer state and turns each beat into
// a job: the set of bus cycles it causes, with the address it needs.
// ---------------------------------------------------------------------------
module nfts_front (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [2:0]                               req_tuser,
   input  logic [nfts_pkg::ADDR_W+nfts_pkg::LEN_W+nfts_pkg::DATA_W-1:0] req_tdata,
   input  nfts_pkg::queue_status_type               queue_status,
   output logic                                     push,
   output nfts_pkg::job_type                        push_job
);
   import nfts_pkg::*;

   localparam logic [2:0] FUNC_READ  = 3'd0;
   localparam logic [2:0] FUNC_WRITE = 3'd1;
   localparam logic [2:0] FUNC_ERASE = 3'd2;
   localparam logic [2:0] FUNC_DATA  = 3'd3;
   localparam logic [2:0] FUNC_READY = 3'd4;

   localparam slot_mask_type ONE = slot_mask_type'(1);
   localparam slot_mask_type ROW3 = (ONE << SLOT_ROW0) | (ONE << SLOT_ROW1)
                                  | (ONE << SLOT_ROW2);
   localparam slot_mask_type ADDR5 = (ONE << SLOT_COL0) | (ONE << SLOT_COL1) | ROW3;
   localparam slot_mask_type READ_OPEN = (ONE << SLOT_CMD00) | ADDR5
                                       | (ONE << SLOT_CMD30) | (ONE << SLOT_WAIT2);
   localparam slot_mask_type WRITE_OPEN = (ONE << SLOT_CMD80) | ADDR5;
   localparam slot_mask_type PROG_CLOSE = (ONE << SLOT_CMD10) | (ONE << SLOT_WAIT);
   localparam slot_mask_type ZERO_CLOSE = (ONE << SLOT_CMD10B) | (ONE << SLOT_WAIT2)
                                        | (ONE << SLOT_DESEL);
   localparam slot_mask_type ERASE_BLOCK = (ONE << SLOT_CMD60) | ROW3
                                         | (ONE << SLOT_CMDD0) | (ONE << SLOT_WAIT2);

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_READ  = 2'd1,
      MODE_WRITE = 2'd2,
      MODE_ERASE = 2'd3
   } mode_type;

   mode_type               mode_ff, mode_in;
   logic [ROW_W-1:0]       page_ff, page_in;
   logic [PAGE_BITS-1:0]   column_ff, column_in;
   logic [LEN_W-1:0]       left_ff, left_in;
   logic [BLK_W-1:0]       blocks_ff, blocks_in;

   logic [ADDR_W-1:0]      addr;
   logic [LEN_W-1:0]       len;
   logic [DATA_W-1:0]      data;
   logic                   accept;
   logic [PAGE_BITS:0]     column_inc;
   logic                   page_end;
   logic                   left_one;
   logic [ROW_W-1:0]       addr_row;
   slot_mask_type          mask;
   logic [ROW_W-1:0]       job_page;
   logic [PAGE_BITS-1:0]   job_column;

   assign addr = req_tdata[ADDR_W-1:0];
   assign len  = req_tdata[ADDR_W+LEN_W-1:ADDR_W];
   assign data = req_tdata[ADDR_W+LEN_W+DATA_W-1:ADDR_W+LEN_W];

   assign req_tready = !queue_status.full;
   assign accept     = req_tvalid && req_tready;

   assign column_inc = {1'b0, column_ff} + (PAGE_BITS+1)'(1);
   assign page_end   = column_inc[PAGE_BITS];
   assign left_one   = (left_ff == LEN_W'(1));
   assign addr_row   = ROW_W'(addr >> PAGE_BITS);

   always_comb begin
      mode_in    = mode_ff;
      page_in    = page_ff;
      column_in  = column_ff;
      left_in    = left_ff;
      blocks_in  = blocks_ff;
      mask       = '0;
      job_page   = page_ff;
      job_column = column_ff;

      if (req_tuser <= FUNC_ERASE && mode_ff != MODE_IDLE) begin
         mask[SLOT_ERR] = 1'b1;
      end else begin
         case (req_tuser)
            FUNC_READ: begin
               page_in    = addr_row;
               column_in  = addr[PAGE_BITS-1:0];
               left_in    = len;
               job_page   = addr_row;
               job_column = addr[PAGE_BITS-1:0];
               mask[SLOT_SEL] = 1'b1;
               if (len == '0) begin
                  mask[SLOT_DESEL] = 1'b1;
               end else begin
                  mask    = mask | READ_OPEN;
                  mode_in = MODE_READ;
               end
            end
            FUNC_WRITE: begin
               page_in    = addr_row;
               column_in  = addr[PAGE_BITS-1:0];
               left_in    = len;
               job_page   = addr_row;
               job_column = addr[PAGE_BITS-1:0];
               mask       = (ONE << SLOT_SEL) | WRITE_OPEN;
               if (len == '0) begin
                  mask      = mask | ZERO_CLOSE;
                  column_in = '0;
               end else begin
                  mode_in = MODE_WRITE;
               end
            end
            FUNC_ERASE: begin
               if (addr[BLOCK_BITS-1:0] != '0 || len[BLOCK_BITS-1:0] != '0) begin
                  mask[SLOT_ERR] = 1'b1;
               end else begin
                  page_in    = addr_row;
                  column_in  = '0;
                  job_page   = addr_row;
                  mask[SLOT_SEL] = 1'b1;
                  if (len == '0) begin
                     mask[SLOT_DESEL] = 1'b1;
                  end else begin
                     blocks_in = len[LEN_W-1:BLOCK_BITS] - BLK_W'(1);
                     mask      = mask | ERASE_BLOCK;
                     mode_in   = MODE_ERASE;
                  end
               end
            end
            FUNC_DATA: begin
               if (mode_ff == MODE_READ) begin
                  mask[SLOT_RDATA] = 1'b1;
                  column_in = column_inc[PAGE_BITS-1:0];
                  left_in   = left_ff - LEN_W'(1);
                  if (left_one) begin
                     mask[SLOT_DESEL] = 1'b1;
                     mode_in = MODE_IDLE;
                  end else if (page_end) begin
                     page_in    = page_ff + ROW_W'(1);
                     job_page   = page_ff + ROW_W'(1);
                     job_column = '0;
                     mask       = mask | READ_OPEN;
                  end
               end else if (mode_ff == MODE_WRITE) begin
                  mask[SLOT_WDATA] = 1'b1;
                  column_in = column_inc[PAGE_BITS-1:0];
                  left_in   = left_ff - LEN_W'(1);
                  if (page_end || left_one) begin
                     mask      = mask | PROG_CLOSE;
                     column_in = '0;
                     if (left_one) begin
                        mask[SLOT_DESEL] = 1'b1;
                        mode_in = MODE_IDLE;
                     end else begin
                        page_in    = page_ff + ROW_W'(1);
                        job_page   = page_ff + ROW_W'(1);
                        job_column = '0;
                        mask       = mask | WRITE_OPEN;
                     end
                  end
               end
            end
            FUNC_READY: begin
               if (mode_ff == MODE_ERASE) begin
                  if (blocks_ff == '0) begin
                     mask[SLOT_DESEL] = 1'b1;
                     mode_in = MODE_IDLE;
                  end else begin
                     blocks_in = blocks_ff - BLK_W'(1);
                     page_in   = page_ff + ROW_W'(PAGES_PER_BLOCK);
                     job_page  = page_ff + ROW_W'(PAGES_PER_BLOCK);
                     mask      = ERASE_BLOCK;
                  end
               end
            end
            default: begin
               mask = '0;
            end
         endcase
      end
   end

   assign push            = accept && (mask != '0);
   assign push_job.mask   = mask;
   assign push_job.page   = job_page;
   assign push_job.column = job_column;
   assign push_job.data   = data;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         page_ff   <= '0;
         column_ff <= '0;
         left_ff   <= '0;
         blocks_ff <= '0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         page_ff   <= page_in;
         column_ff <= column_in;
         left_ff   <= left_in;
         blocks_ff <= blocks_in;
      end
   end

   // A read or write in progress always has at least one byte outstanding.
   `ASSERT_NEVER(a_busy_has_bytes,
      (mode_ff == MODE_READ || mode_ff == MODE_WRITE) && left_ff == '0,
      "transfer active with no bytes left")

endmodule

### rtl/nfts_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// NAND transfer sequencer job queue
// A short first-in first-out buffer of jobs between the front and back end.
// ---------------------------------------------------------------------------
module nfts_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  nfts_pkg::job_type           push_job,
   input  logic                        pop,
   output nfts_pkg::job_type           head_job,
   output nfts_pkg::queue_status_type  status
);
   import nfts_pkg::*;

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]      count_ff, count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head_job     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_NEVER(a_no_push_full, push && status.full, "job pushed into a full queue")
   `ASSERT_NEVER(a_no_pop_empty, pop && status.empty, "job popped from an empty queue")

endmodule

### rtl/nfts_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// NAND transfer sequencer back end
// Walks the slots of each job in order and drives one bus cycle beat per
// clock into the registered response stage while that stage is free.
// ---------------------------------------------------------------------------
module nfts_back (
   input  logic                        clock,
   input  logic                        reset,
   input  nfts_pkg::job_type           head_job,
   input  nfts_pkg::queue_status_type  queue_status,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [2:0]                  rsp_tuser,
   output logic [7:0]                  rsp_tdata,
   output logic                        rsp_tlast
);
   import nfts_pkg::*;

   localparam logic [2:0] KIND_SELECT   = 3'd0;
   localparam logic [2:0] KIND_DESELECT = 3'd1;
   localparam logic [2:0] KIND_COMMAND  = 3'd2;
   localparam logic [2:0] KIND_ADDRESS  = 3'd3;
   localparam logic [2:0] KIND_WDATA    = 3'd4;
   localparam logic [2:0] KIND_RDATA    = 3'd5;
   localparam logic [2:0] KIND_WAIT     = 3'd6;
   localparam logic [2:0] KIND_ERROR    = 3'd7;

   localparam logic [7:0] CMD_READ      = 8'h00;
   localparam logic [7:0] CMD_READ_GO   = 8'h30;
   localparam logic [7:0] CMD_PROGRAM   = 8'h80;
   localparam logic [7:0] CMD_PROG_GO   = 8'h10;
   localparam logic [7:0] CMD_ERASE     = 8'h60;
   localparam logic [7:0] CMD_ERASE_GO  = 8'hD0;

   job_type          cur_ff, cur_in;
   logic             valid_ff, valid_in;
   logic [2:0]       kind_ff, kind_in;
   logic [7:0]       value_ff, value_in;
   logic             last_ff, last_in;

   logic             use_head;
   job_type          eff;
   logic             eff_valid;
   logic             out_free;
   logic             fire;
   slot_mask_type    lowest;
   slot_mask_type    rest;
   logic [15:0]      column16;

   // While the current job is spent, the queue head is worked on directly,
   // so single-beat jobs leave at one per clock while the response stage is free.
   assign use_head  = (cur_ff.mask == '0);
   assign eff       = use_head ? head_job : cur_ff;
   assign eff_valid = use_head ? !queue_status.empty : 1'b1;
   assign out_free  = !valid_ff || rsp_tready;
   assign fire      = out_free && eff_valid;
   assign pop       = fire && use_head;

   assign lowest   = eff.mask & (~eff.mask + slot_mask_type'(1));
   assign rest     = eff.mask & ~lowest;
   assign column16 = 16'(eff.column);

   always_comb begin
      kind_in  = KIND_SELECT;
      value_in = '0;
      unique case (1'b1)
         lowest[SLOT_SEL]:    kind_in = KIND_SELECT;
         lowest[SLOT_ERR]:    kind_in = KIND_ERROR;
         lowest[SLOT_RDATA]:  begin kind_in = KIND_RDATA; value_in = eff.data; end
         lowest[SLOT_WDATA]:  begin kind_in = KIND_WDATA; value_in = eff.data; end
         lowest[SLOT_CMD10]:  begin kind_in = KIND_COMMAND; value_in = CMD_PROG_GO; end
         lowest[SLOT_WAIT]:   kind_in = KIND_WAIT;
         lowest[SLOT_CMD00]:  begin kind_in = KIND_COMMAND; value_in = CMD_READ; end
         lowest[SLOT_CMD80]:  begin kind_in = KIND_COMMAND; value_in = CMD_PROGRAM; end
         lowest[SLOT_CMD60]:  begin kind_in = KIND_COMMAND; value_in = CMD_ERASE; end
         lowest[SLOT_COL0]:   begin kind_in = KIND_ADDRESS; value_in = column16[7:0]; end
         lowest[SLOT_COL1]:   begin kind_in = KIND_ADDRESS; value_in = column16[15:8]; end
         lowest[SLOT_ROW0]:   begin kind_in = KIND_ADDRESS; value_in = eff.page[7:0]; end
         lowest[SLOT_ROW1]:   begin kind_in = KIND_ADDRESS; value_in = eff.page[15:8]; end
         lowest[SLOT_ROW2]:   begin kind_in = KIND_ADDRESS; value_in = eff.page[23:16]; end
         lowest[SLOT_CMD30]:  begin kind_in = KIND_COMMAND; value_in = CMD_READ_GO; end
         lowest[SLOT_CMDD0]:  begin kind_in = KIND_COMMAND; value_in = CMD_ERASE_GO; end
         lowest[SLOT_CMD10B]: begin kind_in = KIND_COMMAND; value_in = CMD_PROG_GO; end
         lowest[SLOT_WAIT2]:  kind_in = KIND_WAIT;
         lowest[SLOT_DESEL]:  kind_in = KIND_DESELECT;
         default: begin
            kind_in  = KIND_SELECT;
            value_in = '0;
         end
      endcase
   end

   always_comb begin
      cur_in   = cur_ff;
      valid_in = valid_ff;
      last_in  = (rest == '0);
      if (fire) begin
         cur_in      = eff;
         cur_in.mask = rest;
         valid_in    = 1'b1;
      end else if (out_free) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff.mask <= '0;
         valid_ff    <= 1'b0;
      end else begin
         cur_ff.mask <= cur_in.mask;
         valid_ff    <= valid_in;
      end
      cur_ff.page   <= cur_in.page;
      cur_ff.column <= cur_in.column;
      cur_ff.data   <= cur_in.data;
      if (fire) begin
         kind_ff  <= kind_in;
         value_ff <= value_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = value_ff;
   assign rsp_tlast  = last_ff;

   // A job with beats still to go was started by a beat still on show or
   // taken in this cycle, so the response stage is never empty then.
   `ASSERT_CLK(a_job_has_beat, (cur_ff.mask != '0) |-> valid_ff,
      "job in progress with an empty response stage")

endmodule

### rtl/nand_flash_transfer_sequencer_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// NAND flash transfer sequencer
// Turns read, write and erase requests for a large-page NAND device into
// the ordered list of bus cycles: select, commands, address bytes, data,
// wait for ready and deselect.
// ---------------------------------------------------------------------------
// Use: request beats arrive on req_*; tuser carries the function (start
// read, start write, start erase, data byte, flash ready) and tdata the
// start address, transfer length and data byte. Each request beat yields
// zero to ten bus cycle beats on rsp_*, with tuser the cycle kind, tdata
// the command, address or data byte and tlast on the final beat of the
// request. Start beats while a transfer runs, and unaligned erases, give a
// single error beat.
// A taken request beat's job is first written into the job queue; its
// first bus cycle beat then goes out from the registered response stage.
// Throughput: one bus cycle beat per clock while rsp_tready is high; a
// request beat is taken every clock while the job queue (four deep) has
// room, so a data stream passes one byte per clock.
// Reset clears the transfer state to idle and empties the queue. When the
// receiver holds rsp_tready low the current beat is held, the queue fills
// and then req_tready falls until beats drain again.
// ---------------------------------------------------------------------------
module nand_flash_transfer_sequencer_unit (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [2:0]    req_tuser,   // func
   input  logic [71:0]   req_tdata,   // start_address, transfer_length, data_byte
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [2:0]    rsp_tuser,   // cycle_kind
   output logic [7:0]    rsp_tdata,   // bus_value
   output logic          rsp_tlast
);
   import nfts_pkg::*;

   logic              push;
   job_type           push_job;
   logic              pop;
   job_type           head_job;
   queue_status_type  queue_status;

   nfts_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tuser    (req_tuser),
      .req_tdata    (req_tdata),
      .queue_status (queue_status),
      .push         (push),
      .push_job     (push_job)
   );

   nfts_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (queue_status)
   );

   nfts_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_job     (head_job),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tuser    (rsp_tuser),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule
